// ===== rtl/core/kws_pkg.sv =====
// ----------------------------------------------------------------------------
// kws_pkg
// shared types and constants of the keyword substitution cipher core
// ----------------------------------------------------------------------------
package kws_pkg;

	localparam int NLET = 26;
	localparam int LW   = 5;

	localparam logic [7:0] LET_A   = 8'd65;
	localparam logic [7:0] LET_Z   = 8'd90;
	localparam logic [7:0] LOW_A   = 8'd97;
	localparam logic [7:0] LOW_Z   = 8'd122;
	localparam logic [7:0] PASS_LO = 8'd32;
	localparam logic [7:0] PASS_HI = 8'd64;
	localparam logic [7:0] NEWLINE = 8'd10;

	// input function codes
	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_KEY    = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;
	localparam logic [1:0] FUNC_TEXT   = 2'd3;

	// queued operation codes
	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_KEY    = 3'd1;
	localparam logic [2:0] OP_FINISH = 3'd2;
	localparam logic [2:0] OP_LETTER = 3'd3;
	localparam logic [2:0] OP_PASS   = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] arg;   // letter index, or raw byte for pass-through
	} kws_op_t;

	typedef struct packed {
		logic              busy;
		logic              table_ready;
		logic [LW-1:0]     fill;
		logic [NLET-1:0]   used;
	} kws_status_t;

endpackage

// ===== rtl/core/kws_ram.sv =====
// ----------------------------------------------------------------------------
// kws_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module kws_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 26
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/kws_front.sv =====
// ----------------------------------------------------------------------------
// kws_front
// classifies incoming beats into queued operations, drops ignored bytes
// ----------------------------------------------------------------------------
module kws_front (
	input  logic [1:0]       func,
	input  logic [7:0]       in_char,
	output logic             keep,
	output kws_pkg::kws_op_t op
);
	import kws_pkg::*;

	logic          is_upper;
	logic          is_lower;
	logic          is_letter;
	logic          is_pass;
	logic [7:0]    li;

	assign is_upper  = (in_char >= LET_A) && (in_char <= LET_Z);
	assign is_lower  = (in_char >= LOW_A) && (in_char <= LOW_Z);
	assign is_letter = is_upper || is_lower;
	assign is_pass   = ((in_char >= PASS_LO) && (in_char <= PASS_HI)) || (in_char == NEWLINE);
	assign li        = is_upper ? (in_char - LET_A) : (in_char - LOW_A);

	always_comb begin
		keep   = 1'b0;
		op.op  = OP_CLEAR;
		op.arg = in_char;
		case (func)
			FUNC_CLEAR: begin
				keep  = 1'b1;
				op.op = OP_CLEAR;
			end
			FUNC_KEY: begin
				// non-letter key bytes never reach the back end
				keep   = is_letter;
				op.op  = OP_KEY;
				op.arg = li;
			end
			FUNC_FINISH: begin
				keep  = 1'b1;
				op.op = OP_FINISH;
			end
			FUNC_TEXT: begin
				if (is_letter) begin
					keep   = 1'b1;
					op.op  = OP_LETTER;
					op.arg = li;
				end else if (is_pass) begin
					keep  = 1'b1;
					op.op = OP_PASS;
				end
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/kws_queue.sv =====
// ----------------------------------------------------------------------------
// kws_queue
// small fifo of classified operations between front and back end
// ----------------------------------------------------------------------------
module kws_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kws_pkg::kws_op_t din,
	output logic             full,
	input  logic             pop,
	output kws_pkg::kws_op_t dout,
	output logic             empty
);
	import kws_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	kws_op_t         mem_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign dout    = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		nxt = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= nxt(wptr_q);
			end
			if (do_pop) begin
				rptr_q <= nxt(rptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/kws_back.sv =====
// ----------------------------------------------------------------------------
// kws_back
// executes queued operations: key building, finish walk, text lookup
// ----------------------------------------------------------------------------
module kws_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  kws_pkg::kws_op_t     head,
	output logic                 pop,
	input  logic                 dir,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_char,
	output kws_pkg::kws_status_t status
);
	import kws_pkg::*;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_FINISH = 1'b1;

	logic            state_q;
	logic [LW-1:0]   walk_q;
	logic [LW-1:0]   fill_q;
	logic [NLET-1:0] used_q;
	logic            ready_q;

	logic            s1_valid_q;
	logic            letter_s1;
	logic            ram_s1;
	logic            dir_s1;
	logic [7:0]      arg_s1;

	logic [7:0]      oq_q [2];
	logic [1:0]      oq_cnt_q;

	logic            idle;
	logic            is_text;
	logic            deq;
	logic [2:0]      occ;
	logic            room;
	logic [LW-1:0]   head_li;
	logic            key_wr;
	logic            fin_wr;
	logic            wr;
	logic [LW-1:0]   wl;
	logic [LW-1:0]   keyed_rd;
	logic [LW-1:0]   inv_rd;
	logic [LW-1:0]   sel_li;
	logic [7:0]      res;

	assign idle    = (state_q == ST_IDLE);
	assign is_text = (head.op == OP_LETTER) || (head.op == OP_PASS);
	assign head_li = head.arg[LW-1:0];
	assign deq     = out_valid && out_ready;
	// results in flight plus those waiting must fit the two-entry output queue
	assign occ     = {1'b0, oq_cnt_q} + {2'b00, s1_valid_q};
	assign room    = occ < (3'd2 + {2'b00, deq});
	assign pop     = head_valid && idle && (!is_text || room);

	assign key_wr = pop && (head.op == OP_KEY) && !used_q[head_li] && (fill_q < LW'(NLET));
	assign fin_wr = (state_q == ST_FINISH) && !used_q[walk_q] && (fill_q < LW'(NLET));
	assign wr     = key_wr || fin_wr;
	assign wl     = fin_wr ? walk_q : head_li;

	// keyed[position] = letter, inverse[letter] = position, written together
	kws_ram #(.WIDTH(LW), .DEPTH(NLET)) u_keyed (
		.clk   (clk),
		.we    (wr),
		.waddr (fill_q),
		.wdata (wl),
		.raddr (head_li),
		.rdata (keyed_rd)
	);

	kws_ram #(.WIDTH(LW), .DEPTH(NLET)) u_inverse (
		.clk   (clk),
		.we    (wr),
		.waddr (wl),
		.wdata (fill_q),
		.raddr (head_li),
		.rdata (inv_rd)
	);

	always_comb begin
		if (ram_s1) begin
			sel_li = dir_s1 ? keyed_rd : inv_rd;
		end else begin
			sel_li = arg_s1[LW-1:0];
		end
		res = letter_s1 ? (LET_A + {3'b000, sel_li}) : arg_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			walk_q     <= '0;
			fill_q     <= '0;
			used_q     <= '0;
			ready_q    <= 1'b0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= pop && is_text;
			if (wr) begin
				fill_q      <= fill_q + 1'b1;
				used_q[wl]  <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && (head.op == OP_CLEAR)) begin
						fill_q  <= '0;
						used_q  <= '0;
						ready_q <= 1'b0;
					end
					if (pop && (head.op == OP_FINISH)) begin
						state_q <= ST_FINISH;
						walk_q  <= LW'(NLET - 1);
					end
				end
				ST_FINISH: begin
					if (walk_q == '0) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end else begin
						walk_q <= walk_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_text) begin
			letter_s1 <= (head.op == OP_LETTER);
			ram_s1    <= ready_q;
			dir_s1    <= dir;
			arg_s1    <= head.arg;
		end
	end

	// two-entry output queue, head in slot zero
	always_ff @(posedge clk) begin
		if (s1_valid_q && !deq) begin
			oq_q[oq_cnt_q[0]] <= res;
		end else if (!s1_valid_q && deq) begin
			oq_q[0] <= oq_q[1];
		end else if (s1_valid_q && deq) begin
			if (oq_cnt_q == 2'd1) begin
				oq_q[0] <= res;
			end else begin
				oq_q[0] <= oq_q[1];
				oq_q[1] <= res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_cnt_q <= '0;
		end else if (s1_valid_q && !deq) begin
			oq_cnt_q <= oq_cnt_q + 1'b1;
		end else if (!s1_valid_q && deq) begin
			oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

	assign out_valid = (oq_cnt_q != 2'd0);
	assign out_char  = oq_q[0];

	assign status.busy        = !idle;
	assign status.table_ready = ready_q;
	assign status.fill        = fill_q;
	assign status.used        = used_q;

endmodule

// ===== rtl/core/keyword_substitution_cipher_core.sv =====
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_core
// builds a keyed alphabet from key beats and substitutes text beats with it
// ----------------------------------------------------------------------------
//
//  channel  signals                          payload
//  -------  -------------------------------  --------------------------------
//  in       in_valid  in_ready               func[1:0], in_char[7:0]
//  out      out_valid out_ready              out_char[7:0]
//  cfg      cfg_valid cfg_ready              direction
//
//  text streams through the back end at one beat per cycle unless out_ready
//  or a finish walk stalls it; results pass the op queue, stage one and the
//  output queue; a finish beat holds the back end while the z-down-to-a walk
//  appends unused letters one per cycle; the front keeps filling the queue
//  reset clears the queue, letter set, fill count and ready flag; the
//  alphabet rams are not cleared; lookups use them only after finish fills them
//  out_ready low only backs up the output queue, then the op queue, then in
//
module keyword_substitution_cipher_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] in_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       direction
);
	import kws_pkg::*;

	logic        direction_q;
	logic        keep;
	kws_op_t     front_op;
	kws_op_t     head_op;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	kws_status_t status;

	// config register, always ready; the user must write it only while no beat is in flight (not enforced)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			direction_q <= direction;
		end
	end

	// dropped beats are accepted too, they simply never enter the queue
	assign in_ready = !q_full;

	kws_front u_front (
		.func    (func),
		.in_char (in_char),
		.keep    (keep),
		.op      (front_op)
	);

	kws_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid && in_ready && keep),
		.din    (front_op),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (head_op),
		.empty  (q_empty)
	);

	kws_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head       (head_op),
		.pop        (q_pop),
		.dir        (direction_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.status     (status)
	);

	// every used letter has exactly one slot in the keyed alphabet
	a_fill_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(status.used) == int'(status.fill))
		else $error("fill count differs from used letter count");

	// a ready table is always a complete permutation
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		status.table_ready |-> (status.fill == LW'(NLET)))
		else $error("table ready with incomplete alphabet");

	// no operation leaves the queue during the finish walk
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> !q_pop)
		else $error("queue popped during finish walk");

	// the walk never shrinks the alphabet
	a_walk_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(status.busy && $past(status.busy)) |-> (status.fill >= $past(status.fill)))
		else $error("fill count dropped during finish walk");

endmodule
